// File: rtl/ssfl_pkg.sv
// Package for the streaming substring search block.
// Holds default sizes, the haystack command struct and the ASCII case-folding function.
// Depends on nothing.
`default_nettype none

package ssfl_pkg;

    localparam int NEEDLE_MAX_DEF   = 32;
    localparam int HAYSTACK_MAX_DEF = 65536;

    typedef struct packed {
        logic [7:0] hay_byte;
        logic       ignore_case;
    } hay_cmd_t;

    function automatic logic [7:0] fold(input logic [7:0] c, input logic on);
        logic [7:0] r;
        r = c;
        if (on && (c >= 8'h41) && (c <= 8'h5A))
        begin
            r = c + 8'h20;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/substring_search_first_last.sv
// Top level of the streaming substring search block.
// Uses ssfl_pkg and instantiates ssfl_match.
//
// Needle bytes (mode 0) are stored, then haystack bytes (mode 1) stream
// through at one item per clock while in_stall is low, with a result item only
// at the haystack byte that carries last_byte. An accepted item is held in the
// input register and its result is written into the output register from there;
// a last haystack byte waits in the input register while an earlier result is
// still stalled at the output. The rate is set by the partial-match vector,
// which is updated from its own register once per haystack byte by a parallel
// compare against all needle positions.
`default_nettype none

module substring_search_first_last
    import ssfl_pkg::*;
#(
    parameter int NEEDLE_MAX   = NEEDLE_MAX_DEF,
    parameter int HAYSTACK_MAX = HAYSTACK_MAX_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        mode,
    input  wire logic [7:0]  data_byte,
    input  wire logic        last_byte,
    input  wire logic        ignore_case,
    input  wire logic        find_last,
    input  wire logic [15:0] from_index,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             found,
    output logic [15:0]      match_index,
    output logic             needle_overflow,
    output logic             haystack_overflow
);

    localparam int LEN_W  = $clog2(NEEDLE_MAX + 1);
    localparam int IDX_W  = (NEEDLE_MAX > 1) ? $clog2(NEEDLE_MAX) : 1;
    localparam int POS_W  = $clog2(HAYSTACK_MAX + 2);
    localparam int CW0    = (POS_W > LEN_W) ? POS_W : LEN_W;
    localparam int CW     = (CW0 > 16) ? CW0 : 16;
    localparam logic [POS_W-1:0] HMAX  = POS_W'(HAYSTACK_MAX);
    localparam logic [LEN_W-1:0] NMAX  = LEN_W'(NEEDLE_MAX);

    logic                        s1_valid_reg;
    logic                        s1_mode_reg;
    logic [7:0]                  s1_byte_reg;
    logic                        s1_last_reg;
    logic                        s1_ic_reg;
    logic                        s1_fl_reg;
    logic [15:0]                 s1_from_reg;

    logic [NEEDLE_MAX-1:0][7:0]  needle_reg;
    logic [LEN_W-1:0]            len_reg;
    logic                        too_long_reg;
    logic                        loading_reg;
    logic [NEEDLE_MAX-1:0]       partial_reg;
    logic [POS_W-1:0]            pos_reg;
    logic                        best_found_reg;
    logic [15:0]                 best_index_reg;
    logic                        lat_ic_reg;
    logic                        lat_fl_reg;
    logic [15:0]                 lat_from_reg;

    logic                        out_valid_reg;
    logic                        found_reg;
    logic [15:0]                 index_reg;
    logic                        nov_reg;
    logic                        hov_reg;

    logic                        s1_go;
    logic                        s1_fire;
    logic                        job_new;
    logic                        eff_ic;
    logic                        eff_fl;
    logic [15:0]                 eff_from;
    logic [NEEDLE_MAX-1:0]       prev_vec;
    logic [NEEDLE_MAX-1:0]       partial_next;
    logic                        full_hit;
    hay_cmd_t                    cmd;
    logic                        in_range;
    logic                        hit;
    logic [POS_W-1:0]            pos_next;
    logic [CW-1:0]               start_pos;
    logic                        best_found_next;
    logic [15:0]                 best_index_next;
    logic                        result_found;
    logic [LEN_W-1:0]            len_eff;
    logic                        too_long_eff;

    assign s1_go    = !(s1_mode_reg && s1_last_reg) || !out_valid_reg || !out_stall;
    assign s1_fire  = s1_valid_reg && s1_go;
    assign in_stall = s1_valid_reg && !s1_go;

    assign job_new  = (pos_reg == '0);
    assign eff_ic   = job_new ? s1_ic_reg   : lat_ic_reg;
    assign eff_fl   = job_new ? s1_fl_reg   : lat_fl_reg;
    assign eff_from = job_new ? s1_from_reg : lat_from_reg;
    assign prev_vec = job_new ? '0 : partial_reg;

    assign cmd.hay_byte    = s1_byte_reg;
    assign cmd.ignore_case = eff_ic;

    ssfl_match #(
        .NEEDLE_MAX (NEEDLE_MAX),
        .LEN_W      (LEN_W)
    ) u_match (
        .needle   (needle_reg),
        .len      (len_reg),
        .prev     (prev_vec),
        .cmd      (cmd),
        .partial  (partial_next),
        .full_hit (full_hit)
    );

    assign in_range  = (pos_reg < HMAX);
    assign hit       = in_range && full_hit && !too_long_reg && (len_reg != '0);
    assign pos_next  = (pos_reg <= HMAX) ? pos_reg + POS_W'(1) : pos_reg;
    assign start_pos = CW'(pos_reg) + CW'(1) - CW'(len_reg);

    always_comb
    begin
        best_found_next = job_new ? 1'b0 : best_found_reg;
        best_index_next = job_new ? 16'd0 : best_index_reg;
        if (hit)
        begin
            if (!eff_fl)
            begin
                if (!best_found_next && (start_pos >= CW'(eff_from)))
                begin
                    best_found_next = 1'b1;
                    best_index_next = start_pos[15:0];
                end
            end
            else if (CW'(pos_reg) <= CW'(eff_from))
            begin
                best_found_next = 1'b1;
                best_index_next = start_pos[15:0];
            end
        end
    end

    assign result_found = best_found_next && (len_reg != '0) && !too_long_reg
                          && (CW'(eff_from) < CW'(pos_next));

    assign len_eff      = loading_reg ? len_reg : '0;
    assign too_long_eff = loading_reg ? too_long_reg : 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_mode_reg <= mode;
            s1_byte_reg <= data_byte;
            s1_last_reg <= last_byte;
            s1_ic_reg   <= ignore_case;
            s1_fl_reg   <= find_last;
            s1_from_reg <= from_index;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && !s1_mode_reg && (len_eff < NMAX))
        begin
            needle_reg[len_eff[IDX_W-1:0]] <= s1_byte_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg        <= '0;
            too_long_reg   <= 1'b0;
            loading_reg    <= 1'b0;
            partial_reg    <= '0;
            pos_reg        <= '0;
            best_found_reg <= 1'b0;
            best_index_reg <= '0;
            lat_ic_reg     <= 1'b0;
            lat_fl_reg     <= 1'b0;
            lat_from_reg   <= '0;
        end
        else if (s1_fire)
        begin
            if (!s1_mode_reg)
            begin
                pos_reg        <= '0;
                partial_reg    <= '0;
                best_found_reg <= 1'b0;
                best_index_reg <= '0;
                loading_reg    <= !s1_last_reg;
                if (len_eff < NMAX)
                begin
                    len_reg      <= len_eff + LEN_W'(1);
                    too_long_reg <= too_long_eff;
                end
                else
                begin
                    len_reg      <= len_eff;
                    too_long_reg <= 1'b1;
                end
            end
            else
            begin
                loading_reg  <= 1'b0;
                lat_ic_reg   <= eff_ic;
                lat_fl_reg   <= eff_fl;
                lat_from_reg <= eff_from;
                if (s1_last_reg)
                begin
                    pos_reg        <= '0;
                    partial_reg    <= '0;
                    best_found_reg <= 1'b0;
                    best_index_reg <= '0;
                end
                else
                begin
                    pos_reg        <= pos_next;
                    partial_reg    <= in_range ? partial_next : prev_vec;
                    best_found_reg <= best_found_next;
                    best_index_reg <= best_index_next;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_fire && s1_mode_reg && s1_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && s1_mode_reg && s1_last_reg)
        begin
            found_reg <= result_found;
            index_reg <= result_found ? best_index_next : 16'd0;
            nov_reg   <= too_long_reg;
            hov_reg   <= (pos_next > HMAX);
        end
    end

    assign out_valid         = out_valid_reg;
    assign found             = found_reg;
    assign match_index       = index_reg;
    assign needle_overflow   = nov_reg;
    assign haystack_overflow = hov_reg;

endmodule

`default_nettype wire

// File: rtl/ssfl_match.sv
// Parallel compare of one haystack byte against every stored needle byte.
// Produces the next partial-match vector and the full-match flag.
// Depends on ssfl_pkg.
`default_nettype none

module ssfl_match
    import ssfl_pkg::*;
#(
    parameter int NEEDLE_MAX = NEEDLE_MAX_DEF,
    parameter int LEN_W      = $clog2(NEEDLE_MAX + 1)
)
(
    input  wire logic [NEEDLE_MAX-1:0][7:0] needle,
    input  wire logic [LEN_W-1:0]           len,
    input  wire logic [NEEDLE_MAX-1:0]      prev,
    input  wire hay_cmd_t                   cmd,
    output logic      [NEEDLE_MAX-1:0]      partial,
    output logic                            full_hit
);

    logic [7:0] hb;

    assign hb = fold(cmd.hay_byte, cmd.ignore_case);

    for (genvar i = 0; i < NEEDLE_MAX; i++)
    begin : g_pos
        logic chain;
        logic eq;
        if (i == 0)
        begin : g_first
            assign chain = 1'b1;
        end
        else
        begin : g_rest
            assign chain = prev[i-1];
        end
        assign eq         = (fold(needle[i], cmd.ignore_case) == hb);
        assign partial[i] = (LEN_W'(i) < len) && chain && eq;
    end

    always_comb
    begin
        full_hit = 1'b0;
        for (int i = 0; i < NEEDLE_MAX; i++)
        begin
            if (len == LEN_W'(i + 1))
            begin
                full_hit = partial[i];
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/ssfl_checker.sv
// Port-level checks for substring_search_first_last, bound to the top level.
// Depends on the top level's port list only.
`default_nettype none

module ssfl_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_stall,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic        found,
    input wire logic [15:0] match_index,
    input wire logic        needle_overflow,
    input wire logic        haystack_overflow
);

    // A result item that is held back keeps its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(found)
            && $stable(match_index) && $stable(needle_overflow)
            && $stable(haystack_overflow))
        else $error("result item changed while stalled");

    // Input stalls only while a finished result waits at the output.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without a waiting result");

    // A needle that overflowed never yields a match.
    a_overflow_nf: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(found && needle_overflow))
        else $error("match reported with needle overflow");

    // The index is zero when nothing was found.
    a_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> match_index == 16'd0)
        else $error("nonzero index without a match");

endmodule

bind substring_search_first_last ssfl_checker u_ssfl_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_stall          (in_stall),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .found             (found),
    .match_index       (match_index),
    .needle_overflow   (needle_overflow),
    .haystack_overflow (haystack_overflow)
);

`default_nettype wire

// File: test/substring_search_first_last_test.sv
// Self-checking testbench for the streaming substring search block.
// Depends on ssfl_pkg and substring_search_first_last; predicts each result
// from the accepted items and compares it with the block's output.
`timescale 1ns / 1ps

module substring_search_first_last_test;

    localparam int NEEDLE_MAX   = ssfl_pkg::NEEDLE_MAX_DEF;
    localparam int HAYSTACK_MAX = ssfl_pkg::HAYSTACK_MAX_DEF;
    localparam bit MODE_NEEDLE   = 1'b0;
    localparam bit MODE_HAYSTACK = 1'b1;
    localparam int RANDOM_ITEMS  = 1950;
    localparam int DRAIN_CYCLES  = 16;
    localparam int CYCLE_LIMIT   = 2000000;

    typedef struct {
        bit        mode;
        bit [7:0]  data_byte;
        bit        last_byte;
        bit        ignore_case;
        bit        find_last;
        bit [15:0] from_index;
    } search_item_t;

    typedef struct {
        bit        found;
        bit [15:0] match_index;
        bit        needle_overflow;
        bit        haystack_overflow;
    } search_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        mode = 1'b0;
    logic [7:0]  data_byte = 8'h00;
    logic        last_byte = 1'b0;
    logic        ignore_case = 1'b0;
    logic        find_last = 1'b0;
    logic [15:0] from_index = 16'h0000;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        found;
    logic [15:0] match_index;
    logic        needle_overflow;
    logic        haystack_overflow;

    search_item_t   pending_items[$];
    search_result_t expected_results[$];
    search_item_t   drv_item;
    int unsigned    items_made = 0;
    int unsigned    items_accepted = 0;
    int unsigned    failures = 0;
    int unsigned    cycle_count = 0;
    int unsigned    burst_left = 0;
    int unsigned    gap_left = 0;
    int unsigned    phase_left = 0;

    logic [7:0]            ndl_bytes [NEEDLE_MAX];
    int unsigned           ndl_len = 0;
    bit                    ndl_over = 1'b0;
    bit                    ndl_loading = 1'b0;
    bit [NEEDLE_MAX-1:0]   partial = '0;
    int unsigned           hay_pos = 0;
    bit                    best_ok = 1'b0;
    int unsigned           best_at = 0;
    bit                    opt_fold = 1'b0;
    bit                    opt_last = 1'b0;
    int unsigned           opt_from = 0;

    substring_search_first_last dut
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .mode              (mode),
        .data_byte         (data_byte),
        .last_byte         (last_byte),
        .ignore_case       (ignore_case),
        .find_last         (find_last),
        .from_index        (from_index),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .found             (found),
        .match_index       (match_index),
        .needle_overflow   (needle_overflow),
        .haystack_overflow (haystack_overflow)
    );

    always #4 clk = ~clk;

    function automatic logic [7:0] to_lower(input logic [7:0] c, input bit on);
        if (on && (c >= 8'h41) && (c <= 8'h5A))
        begin
            return c + 8'h20;
        end
        return c;
    endfunction

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 8))
            0: return 8'h61;
            1: return 8'h41;
            2: return 8'h62;
            3: return 8'h42;
            4: return 8'h7A;
            5: return 8'h5A;
            6: return 8'h40;
            7: return 8'h60;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic push_item(input bit m, input bit [7:0] b, input bit lst,
                             input bit ic, input bit fl, input bit [15:0] from);
        search_item_t it;
        it.mode        = m;
        it.data_byte   = b;
        it.last_byte   = lst;
        it.ignore_case = ic;
        it.find_last   = fl;
        it.from_index  = from;
        pending_items.push_back(it);
        items_made++;
    endtask

    task automatic clear_search();
        partial = '0;
        hay_pos = 0;
        best_ok = 1'b0;
        best_at = 0;
    endtask

    task automatic search_step(input search_item_t it);
        search_result_t r;
        bit             prev;
        int unsigned    start;
        if (it.mode == MODE_NEEDLE)
        begin
            if (hay_pos != 0)
            begin
                clear_search();
            end
            if (!ndl_loading)
            begin
                ndl_len = 0;
                ndl_over = 1'b0;
                ndl_loading = 1'b1;
            end
            if (ndl_len < NEEDLE_MAX)
            begin
                ndl_bytes[ndl_len] = it.data_byte;
                ndl_len++;
            end
            else
            begin
                ndl_over = 1'b1;
            end
            if (it.last_byte)
            begin
                ndl_loading = 1'b0;
            end
            return;
        end
        ndl_loading = 1'b0;
        if (hay_pos == 0)
        begin
            clear_search();
            opt_fold = it.ignore_case;
            opt_last = it.find_last;
            opt_from = it.from_index;
        end
        if (hay_pos < HAYSTACK_MAX)
        begin
            for (int i = int'(ndl_len) - 1; i >= 0; i--)
            begin
                if (i == 0)
                begin
                    prev = 1'b1;
                end
                else
                begin
                    prev = partial[i-1];
                end
                partial[i] = prev && (to_lower(ndl_bytes[i], opt_fold)
                                      == to_lower(it.data_byte, opt_fold));
            end
            if ((ndl_len > 0) && !ndl_over && partial[ndl_len-1])
            begin
                start = hay_pos + 1 - ndl_len;
                if (!opt_last)
                begin
                    if (!best_ok && (start >= opt_from))
                    begin
                        best_ok = 1'b1;
                        best_at = start;
                    end
                end
                else if (hay_pos <= opt_from)
                begin
                    best_ok = 1'b1;
                    best_at = start;
                end
            end
        end
        if (hay_pos <= HAYSTACK_MAX)
        begin
            hay_pos++;
        end
        if (it.last_byte)
        begin
            r.found = best_ok && (ndl_len > 0) && !ndl_over && (opt_from < hay_pos);
            r.match_index = r.found ? best_at[15:0] : 16'h0000;
            r.needle_overflow = ndl_over;
            r.haystack_overflow = (hay_pos > HAYSTACK_MAX);
            expected_results.push_back(r);
            clear_search();
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            burst_left <= 0;
            gap_left <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                search_step(drv_item);
                items_accepted++;
            end
            if (!in_valid || !in_stall)
            begin
                if (gap_left != 0)
                begin
                    in_valid <= 1'b0;
                    gap_left <= gap_left - 1;
                end
                else if (pending_items.size() != 0)
                begin
                    drv_item = pending_items.pop_front();
                    in_valid <= 1'b1;
                    mode <= drv_item.mode;
                    data_byte <= drv_item.data_byte;
                    last_byte <= drv_item.last_byte;
                    ignore_case <= drv_item.ignore_case;
                    find_last <= drv_item.find_last;
                    from_index <= drv_item.from_index;
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 30);
                        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
                    end
                    else
                    begin
                        burst_left <= burst_left - 1;
                    end
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        search_result_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            phase_left <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result: found=%0d match_index=%0d", found, match_index);
                    failures++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (found !== want.found)
                    begin
                        $error("found: expected %0d, actual %0d", want.found, found);
                        failures++;
                    end
                    if (match_index !== want.match_index)
                    begin
                        $error("match_index: expected %0d, actual %0d",
                               want.match_index, match_index);
                        failures++;
                    end
                    if (needle_overflow !== want.needle_overflow)
                    begin
                        $error("needle_overflow: expected %0d, actual %0d",
                               want.needle_overflow, needle_overflow);
                        failures++;
                    end
                    if (haystack_overflow !== want.haystack_overflow)
                    begin
                        $error("haystack_overflow: expected %0d, actual %0d",
                               want.haystack_overflow, haystack_overflow);
                        failures++;
                    end
                end
            end
            if (phase_left != 0)
            begin
                phase_left <= phase_left - 1;
            end
            else if (out_stall)
            begin
                out_stall <= 1'b0;
                phase_left <= $urandom_range(0, 40);
            end
            else
            begin
                out_stall <= ($urandom_range(0, 3) != 0);
                phase_left <= $urandom_range(0, 6);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin : stimulus
        logic [7:0]  gen_needle[$];
        logic [7:0]  hay_bytes[$];
        logic [7:0]  b;
        logic [15:0] from;
        int unsigned base;
        int unsigned len;
        int unsigned r;
        int unsigned p;
        bit          ic;
        bit          fl;
        bit          need_ndl;

        // Empty needle after reset, then case folding in both modes.
        push_item(MODE_HAYSTACK, 8'h71, 1'b1, 1'b0, 1'b0, 16'h0000);
        push_item(MODE_NEEDLE, 8'h41, 1'b0, 1'b0, 1'b0, 16'h0000);
        push_item(MODE_NEEDLE, 8'h62, 1'b1, 1'b0, 1'b0, 16'h0000);
        push_item(MODE_HAYSTACK, 8'h61, 1'b0, 1'b1, 1'b0, 16'h0001);
        push_item(MODE_HAYSTACK, 8'h42, 1'b0, 1'b0, 1'b1, 16'h0000);
        push_item(MODE_HAYSTACK, 8'h61, 1'b0, 1'b0, 1'b0, 16'h0000);
        push_item(MODE_HAYSTACK, 8'h62, 1'b1, 1'b0, 1'b0, 16'h0000);
        push_item(MODE_HAYSTACK, 8'h41, 1'b0, 1'b0, 1'b1, 16'hFFFF);
        push_item(MODE_HAYSTACK, 8'h62, 1'b0, 1'b1, 1'b0, 16'h0000);
        push_item(MODE_HAYSTACK, 8'h41, 1'b0, 1'b0, 1'b0, 16'h0000);
        push_item(MODE_HAYSTACK, 8'h62, 1'b1, 1'b0, 1'b0, 16'h0000);
        // A start index at the haystack end finds nothing.
        push_item(MODE_HAYSTACK, 8'h41, 1'b0, 1'b0, 1'b0, 16'h0002);
        push_item(MODE_HAYSTACK, 8'h62, 1'b1, 1'b0, 1'b0, 16'h0000);
        // A needle byte drops the open haystack job.
        push_item(MODE_HAYSTACK, 8'h41, 1'b0, 1'b0, 1'b0, 16'h0000);
        push_item(MODE_NEEDLE, 8'hFF, 1'b0, 1'b1, 1'b1, 16'hFFFF);
        push_item(MODE_NEEDLE, 8'h00, 1'b1, 1'b0, 1'b0, 16'h0000);
        push_item(MODE_HAYSTACK, 8'hFF, 1'b0, 1'b0, 1'b0, 16'h0000);
        push_item(MODE_HAYSTACK, 8'h00, 1'b1, 1'b1, 1'b1, 16'hFFFF);
        // A needle without a last byte is closed by the haystack.
        push_item(MODE_NEEDLE, 8'h5A, 1'b0, 1'b0, 1'b0, 16'h0000);
        push_item(MODE_HAYSTACK, 8'h7A, 1'b0, 1'b1, 1'b0, 16'h0000);
        push_item(MODE_HAYSTACK, 8'h5A, 1'b1, 1'b0, 1'b0, 16'h0000);

        // The random part starts from a known two-byte needle.
        push_item(MODE_NEEDLE, 8'h61, 1'b0, 1'b0, 1'b0, 16'h0000);
        push_item(MODE_NEEDLE, 8'h62, 1'b1, 1'b0, 1'b0, 16'h0000);
        gen_needle = '{8'h61, 8'h62};

        base = items_made;
        need_ndl = 1'b0;
        while (items_made - base < RANDOM_ITEMS)
        begin
            if (need_ndl || ($urandom_range(0, 4) == 0))
            begin
                r = $urandom_range(0, 9);
                if (r < 6)
                begin
                    len = $urandom_range(1, 3);
                end
                else if (r < 8)
                begin
                    len = $urandom_range(4, 12);
                end
                else if (r == 8)
                begin
                    len = $urandom_range(13, NEEDLE_MAX);
                end
                else
                begin
                    len = $urandom_range(NEEDLE_MAX + 1, NEEDLE_MAX + 4);
                end
                gen_needle.delete();
                for (p = 0; p < len; p++)
                begin
                    b = pick_byte();
                    gen_needle.push_back(b);
                    push_item(MODE_NEEDLE, b, (p == len - 1) && ($urandom_range(0, 9) != 0),
                              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                              16'($urandom));
                end
                need_ndl = 1'b0;
            end
            else
            begin
                len = $urandom_range(1, 30);
                ic = 1'($urandom_range(0, 1));
                fl = 1'($urandom_range(0, 1));
                case ($urandom_range(0, 5))
                    0: from = 16'h0000;
                    1: from = 16'hFFFF;
                    2: from = 16'($urandom);
                    default: from = 16'($urandom_range(0, len + 1));
                endcase
                need_ndl = ($urandom_range(0, 19) == 0);
                hay_bytes.delete();
                while (hay_bytes.size() < len)
                begin
                    if ((gen_needle.size() <= NEEDLE_MAX)
                        && (hay_bytes.size() + gen_needle.size() <= len)
                        && ($urandom_range(0, 4) == 0))
                    begin
                        for (p = 0; p < gen_needle.size(); p++)
                        begin
                            b = gen_needle[p];
                            if (ic && ((b | 8'h20) >= 8'h61) && ((b | 8'h20) <= 8'h7A)
                                && ($urandom_range(0, 1) == 0))
                            begin
                                b = b ^ 8'h20;
                            end
                            hay_bytes.push_back(b);
                        end
                    end
                    else
                    begin
                        hay_bytes.push_back(pick_byte());
                    end
                end
                for (p = 0; p < hay_bytes.size(); p++)
                begin
                    if (p == 0)
                    begin
                        push_item(MODE_HAYSTACK, hay_bytes[p], (len == 1) && !need_ndl,
                                  ic, fl, from);
                    end
                    else
                    begin
                        push_item(MODE_HAYSTACK, hay_bytes[p],
                                  (p == hay_bytes.size() - 1) && !need_ndl,
                                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                  16'($urandom));
                    end
                end
            end
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        while (items_accepted != items_made)
        begin
            @(posedge clk);
        end
        while (expected_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (failures == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
